/* rtl/bpss_pkg.sv */
package bpss_pkg;

	localparam logic [15:0] MIN_IMPROVEMENT_RESET = 16'd10;

	localparam int unsigned STEP_W = 3;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PRIME  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LAST   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DECIDE = 3'd4;

	localparam logic REQ_UPDATE   = 1'b0;
	localparam logic REQ_EVALUATE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  entry_index;
		logic        present;
		logic [1:0]  tx_state;
		logic        receiving;
		logic [31:0] pair_priority;
		logic [15:0] round_trip;
	} req_t;

	typedef struct packed {
		logic       switched;
		logic [2:0] new_index;
		logic [2:0] best_index;
		logic       any_present;
	} res_t;

	typedef struct packed {
		logic [1:0]  tx_state;
		logic        receiving;
		logic [31:0] prio;
		logic [15:0] rtt;
	} entry_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_CNT  = 2'd1,
		RD_SEL  = 2'd2
	} rd_src_t;

	typedef enum logic [1:0] {
		J_ALWAYS      = 2'd0,
		J_ON_EVAL     = 2'd1,
		J_ON_SCAN_END = 2'd2
	} jump_t;

	typedef struct packed {
		logic              busy;
		rd_src_t           rd_src;
		logic              cnt_inc;
		logic              do_cmp;
		logic              do_decide;
		jump_t             jump;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{busy: 1'b0, rd_src: RD_NONE, cnt_inc: 1'b0, do_cmp: 1'b0,
			do_decide: 1'b0, jump: J_ON_EVAL, target: STEP_PRIME};
		unique case (step)
			STEP_IDLE: begin
				w = '{busy: 1'b0, rd_src: RD_NONE, cnt_inc: 1'b0, do_cmp: 1'b0,
					do_decide: 1'b0, jump: J_ON_EVAL, target: STEP_PRIME};
			end
			STEP_PRIME: begin
				w = '{busy: 1'b1, rd_src: RD_CNT, cnt_inc: 1'b1, do_cmp: 1'b0,
					do_decide: 1'b0, jump: J_ALWAYS, target: STEP_SCAN};
			end
			STEP_SCAN: begin
				w = '{busy: 1'b1, rd_src: RD_CNT, cnt_inc: 1'b1, do_cmp: 1'b1,
					do_decide: 1'b0, jump: J_ON_SCAN_END, target: STEP_LAST};
			end
			STEP_LAST: begin
				w = '{busy: 1'b1, rd_src: RD_SEL, cnt_inc: 1'b0, do_cmp: 1'b1,
					do_decide: 1'b0, jump: J_ALWAYS, target: STEP_DECIDE};
			end
			STEP_DECIDE: begin
				w = '{busy: 1'b1, rd_src: RD_NONE, cnt_inc: 1'b0, do_cmp: 1'b0,
					do_decide: 1'b1, jump: J_ALWAYS, target: STEP_IDLE};
			end
			default: begin
				w = '{busy: 1'b0, rd_src: RD_NONE, cnt_inc: 1'b0, do_cmp: 1'b0,
					do_decide: 1'b0, jump: J_ALWAYS, target: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/best_path_switch_selector_core.sv */
// best path switch selector
// start/busy command channel: a request is taken at an edge with start high and
// busy low. an update writes one table entry (indexes at or above NUM_PATHS are
// dropped); an evaluate ranks all present entries and may switch the selection.
// every request gives one result on result, marked by done for exactly one
// cycle; the receiver cannot stall, so done is never held.
// update: result (all zero) is registered in the cycle after accept; busy stays
// low, so updates can follow back to back.
// evaluate: a microcoded sequencer walks the table through one read port and
// one rank comparator, one entry per cycle, then reads the selected entry's
// round-trip time; the next request can be taken at the edge that ends the done
// cycle.
// cfg_valid/cfg_ready writes min_improvement; cfg_ready is always high and
// writes are expected only while no request is in flight.
// reset: all entries not present, no selection, min_improvement back to 10.
module best_path_switch_selector_core #(
	parameter int NUM_PATHS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bpss_pkg::req_t   req,
	output logic             done,
	output bpss_pkg::res_t   result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data
);
	import bpss_pkg::*;

	localparam int IDX_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
	localparam int AW    = (IDX_W > 3) ? IDX_W : 3;

	ctrl_t ctrl;

	logic             accept;
	logic             eval_go;
	logic             upd_go;
	logic             scan_end;

	logic [15:0]      min_imp_q;
	logic [NUM_PATHS-1:0] present_q;
	entry_t           entry_mem_q [NUM_PATHS];

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_present_q;
	entry_t           rd_data_q;

	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             any_q;
	logic             sel_valid_q;
	logic [IDX_W-1:0] sel_idx_q;

	logic             done_q;
	res_t             result_q;

	logic [AW-1:0]    wr_ext;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_in_range;
	logic [AW-1:0]    best_ext;
	logic             take;
	logic [16:0]      need;
	logic             sw;

	function automatic logic ranks_above(input entry_t x, input entry_t y);
		logic r;
		if (x.tx_state != y.tx_state) begin
			r = x.tx_state < y.tx_state;
		end else if (x.receiving != y.receiving) begin
			r = x.receiving;
		end else if (x.prio != y.prio) begin
			r = x.prio > y.prio;
		end else begin
			r = x.rtt < y.rtt;
		end
		return r;
	endfunction

	assign busy      = ctrl.busy;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign eval_go   = accept && (req.req_type == REQ_EVALUATE);
	assign upd_go    = accept && (req.req_type == REQ_UPDATE);
	assign scan_end  = (cnt_q == IDX_W'(NUM_PATHS - 1));

	bpss_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.eval_go  (eval_go),
		.scan_end (scan_end),
		.ctrl     (ctrl)
	);

	assign wr_ext      = AW'(req.entry_index);
	assign wr_addr     = wr_ext[IDX_W-1:0];
	assign wr_in_range = (32'(req.entry_index) < NUM_PATHS);

	always_comb begin
		case (ctrl.rd_src)
			RD_SEL:  rd_addr = sel_idx_q;
			default: rd_addr = cnt_q;
		endcase
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (upd_go && wr_in_range) begin
			entry_mem_q[wr_addr] <= '{tx_state: req.tx_state,
				receiving: req.receiving, prio: req.pair_priority,
				rtt: req.round_trip};
		end
		if (ctrl.rd_src != RD_NONE) begin
			rd_data_q    <= entry_mem_q[rd_addr];
			rd_idx_q     <= rd_addr;
			rd_present_q <= present_q[rd_addr];
		end
	end

	assign take = ctrl.do_cmp && rd_present_q && (!any_q || ranks_above(rd_data_q, best_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= rd_data_q;
		end
	end

	// rtt margin: best + margin must not exceed the selected entry's rtt
	assign need = {1'b0, best_q.rtt} + {1'b0, min_imp_q};
	always_comb begin
		sw = 1'b0;
		if (any_q && (best_q.tx_state <= 2'd1) &&
			!(sel_valid_q && (sel_idx_q == best_idx_q))) begin
			sw = !sel_valid_q || (need <= {1'b0, rd_data_q.rtt});
		end
	end

	assign best_ext = AW'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_imp_q   <= MIN_IMPROVEMENT_RESET;
			present_q   <= '0;
			cnt_q       <= '0;
			best_idx_q  <= '0;
			any_q       <= 1'b0;
			sel_valid_q <= 1'b0;
			sel_idx_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_imp_q <= cfg_data;
			end
			if (upd_go && wr_in_range) begin
				present_q[wr_addr] <= req.present;
			end
			if (eval_go) begin
				cnt_q      <= '0;
				best_idx_q <= '0;
				any_q      <= 1'b0;
			end else if (ctrl.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take) begin
				best_idx_q <= rd_idx_q;
				any_q      <= 1'b1;
			end
			if (ctrl.do_decide && sw) begin
				sel_valid_q <= 1'b1;
				sel_idx_q   <= best_idx_q;
			end
			done_q <= upd_go || ctrl.do_decide;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			result_q <= '0;
		end else if (ctrl.do_decide) begin
			result_q.switched    <= sw;
			result_q.new_index   <= sw ? best_ext[2:0] : 3'd0;
			result_q.best_index  <= any_q ? best_ext[2:0] : 3'd0;
			result_q.any_present <= any_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/bpss_seq.sv */
module bpss_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            eval_go,
	input  logic            scan_end,
	output bpss_pkg::ctrl_t ctrl
);
	import bpss_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;

	assign ctrl = ucode(pc_q);

	always_comb begin
		unique case (ctrl.jump)
			J_ALWAYS:      pc_d = ctrl.target;
			J_ON_EVAL:     pc_d = eval_go ? ctrl.target : pc_q;
			J_ON_SCAN_END: pc_d = scan_end ? ctrl.target : pc_q;
			default:       pc_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import bpss_pkg::*;

	localparam int PATHS      = 8;
	localparam int PHASES     = 6;
	localparam int PHASE_CMDS = 316;
	localparam int QUIET_MAX  = 2000;
	localparam int CMD_DEPTH  = 4096;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	res_t        result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// commands waiting for the driver, and selections expected back from the block
	req_t path_cmds[CMD_DEPTH];
	res_t sel_expect[CMD_DEPTH];

	// predictor copy of the path table and the selection
	logic        path_present[PATHS];
	entry_t      path_tab[PATHS];
	logic        sel_valid;
	logic [2:0]  sel_idx;
	logic [15:0] gain_margin;

	logic steady = 1'b0;
	int   n_pushed = 0;
	int   n_sent = 0;
	int   n_taken = 0;
	int   exp_rd = 0;
	int   n_updates = 0;
	int   n_evals = 0;
	int   n_switches = 0;
	int   n_results = 0;
	int   errors = 0;
	int   quiet = 0;

	best_path_switch_selector_core #(.NUM_PATHS(PATHS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic outranks(input entry_t x, input entry_t y);
		if (x.tx_state != y.tx_state)
			return x.tx_state < y.tx_state;
		if (x.receiving != y.receiving)
			return x.receiving > y.receiving;
		if (x.prio != y.prio)
			return x.prio > y.prio;
		return x.rtt < y.rtt;
	endfunction

	function automatic res_t rank_and_select(input req_t r);
		res_t       o;
		logic       any;
		logic [2:0] b;
		o = '0;
		any = 1'b0;
		b = '0;
		if (r.req_type == REQ_UPDATE) begin
			path_present[r.entry_index] = r.present;
			path_tab[r.entry_index] = '{tx_state: r.tx_state, receiving: r.receiving,
				prio: r.pair_priority, rtt: r.round_trip};
			return o;
		end
		for (int i = 0; i < PATHS; i++) begin
			// strict compare keeps the lowest index on a full tie
			if (path_present[i] && (!any || outranks(path_tab[i], path_tab[b]))) begin
				b = 3'(i);
				any = 1'b1;
			end
		end
		if (any && path_tab[b].tx_state <= 2'd1 && !(sel_valid && sel_idx == b)) begin
			// margin test is on the selected entry's current time, present or not
			if (!sel_valid ||
				17'(path_tab[b].rtt) + 17'(gain_margin) <= 17'(path_tab[sel_idx].rtt)) begin
				sel_valid = 1'b1;
				sel_idx = b;
				o.switched = 1'b1;
				o.new_index = b;
			end
		end
		o.best_index = any ? b : 3'd0;
		o.any_present = any;
		return o;
	endfunction

	function automatic req_t rand_bits_cmd(input logic kind);
		logic [55:0] bits;
		req_t        r;
		bits = {$urandom(), 24'($urandom())};
		r = bits;
		r.req_type = kind;
		return r;
	endfunction

	function automatic req_t rand_update();
		req_t r;
		r = rand_bits_cmd(REQ_UPDATE);
		r.present = ($urandom_range(9) < 8);
		r.tx_state = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
		case ($urandom_range(3))
			0: r.pair_priority = 32'd0;
			1: r.pair_priority = 32'hffff_ffff;
			2: r.pair_priority = 32'($urandom_range(3));
			default: r.pair_priority = $urandom();
		endcase
		case ($urandom_range(4))
			0: r.round_trip = 16'd0;
			1: r.round_trip = 16'hffff;
			2, 3: r.round_trip = 16'($urandom_range(300));
			default: r.round_trip = 16'($urandom_range(65535));
		endcase
		return r;
	endfunction

	task automatic add_cmd(input req_t r);
		path_cmds[n_pushed] = r;
		n_pushed++;
	endtask

	task automatic queue_update(input int idx, input logic pres, input logic [1:0] ws,
		input logic rcv, input logic [31:0] prio, input logic [15:0] rtt);
		add_cmd('{req_type: REQ_UPDATE, entry_index: 3'(idx), present: pres,
			tx_state: ws, receiving: rcv, pair_priority: prio, round_trip: rtt});
	endtask

	task automatic queue_eval();
		add_cmd(rand_bits_cmd(REQ_EVALUATE));
	endtask

	task automatic wait_drained();
		while (n_taken != n_pushed || n_taken != exp_rd)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_min_gain(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		gain_margin = v;
		cfg_valid <= 1'b0;
	endtask

	// driver: start stays up until the block takes the transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				if (req.req_type == REQ_EVALUATE)
					n_evals++;
				else
					n_updates++;
				sel_expect[n_taken] = rank_and_select(req);
				n_taken++;
			end
			if (!start || !busy) begin
				if (n_sent < n_pushed && (steady || $urandom_range(99) >= 20)) begin
					req <= path_cmds[n_sent];
					n_sent++;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			n_results++;
			if (exp_rd >= n_taken) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: %p", result);
			end else begin
				want = sel_expect[exp_rd];
				exp_rd++;
				if (want.switched && result.switched === 1'b1)
					n_switches++;
				if (result.switched !== want.switched || result.new_index !== want.new_index ||
					result.best_index !== want.best_index ||
					result.any_present !== want.any_present) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at result %0d: expected %p, got %p",
							n_results, want, result);
				end
			end
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_MAX) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		logic [15:0] gains[PHASES];
		int          left;
		int          k;
		for (int i = 0; i < PATHS; i++) begin
			path_present[i] = 1'b0;
			path_tab[i] = '0;
		end
		sel_valid = 1'b0;
		sel_idx = '0;
		gain_margin = MIN_IMPROVEMENT_RESET;
		gains = '{16'd0, 16'hffff, 16'd1, 16'd40, 16'($urandom_range(65535)), 16'd10};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill every entry first so nothing unwritten is ever read
		for (int i = 0; i < PATHS; i++)
			queue_update(i, 1'b0, 2'(i), i[0], i[0] ? 32'hffff_ffff : 32'd0,
				i[0] ? 16'hffff : 16'd0);
		queue_eval();                                          // nothing present
		queue_update(7, 1'b1, 2'd3, 1'b0, 32'd0, 16'hffff);
		queue_eval();                                          // best not ready to send
		queue_update(2, 1'b1, 2'd1, 1'b1, 32'hffff_ffff, 16'd100);
		queue_eval();                                          // first selection
		queue_update(5, 1'b1, 2'd0, 1'b0, 32'd0, 16'd95);
		queue_eval();                                          // gain short of margin
		queue_update(5, 1'b1, 2'd0, 1'b0, 32'd0, 16'd90);
		queue_eval();                                          // gain exactly at margin
		queue_eval();                                          // best already selected
		queue_update(5, 1'b0, 2'd0, 1'b0, 32'd0, 16'd5);
		queue_eval();                                          // selected time below margin
		queue_update(0, 1'b1, 2'd0, 1'b1, 32'd7, 16'd0);
		queue_update(3, 1'b1, 2'd0, 1'b1, 32'd7, 16'd0);
		queue_eval();                                          // full tie, lower index wins
		queue_update(4, 1'b1, 2'd2, 1'b1, 32'hffff_ffff, 16'd0);
		queue_eval();
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_min_gain(gains[p]);
			steady = (p == 2);
			left = PHASE_CMDS;
			while (left > 0) begin
				if ($urandom_range(9) < 8) begin
					// a few updates, then an evaluate
					k = $urandom_range(4, 1);
					for (int j = 0; j < k; j++)
						add_cmd(rand_update());
					queue_eval();
					left -= k + 1;
				end else begin
					add_cmd(rand_bits_cmd(1'($urandom_range(1))));
					left--;
				end
			end
			wait_drained();
		end

		if (n_taken != exp_rd) begin
			errors += n_taken - exp_rd;
			$display("%0d expected results never arrived", n_taken - exp_rd);
		end
		$display("covered %0d updates and %0d evaluates, %0d of them switching the path",
			n_updates, n_evals, n_switches);
		$display("min_improvement swept over %0d settings including 0 and 65535, %0d mismatches",
			PHASES, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
